### rtl/core/sxg_pkg.sv
// ----------------------------------------------------------------------------
// sxg_pkg
// Shared constants, register indexes and types of the horizontal gradient
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sxg_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int PIXEL_BITS_DEFAULT = 8;
  localparam int COEF_BITS_DEFAULT  = 12;

  // Width of the image size registers and of the row counter.
  localparam int DIM_BITS       = 12;
  localparam int CFG_INDEX_BITS = 4;

  // Number of weights and depth of the result queue.
  localparam int NUM_COEFS  = 6;
  localparam int FIFO_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH       = 4'd0,
    REG_IMAGE_HEIGHT      = 4'd1,
    REG_COEF_TOP_LEFT     = 4'd2,
    REG_COEF_TOP_RIGHT    = 4'd3,
    REG_COEF_MID_LEFT     = 4'd4,
    REG_COEF_MID_RIGHT    = 4'd5,
    REG_COEF_BOTTOM_LEFT  = 4'd6,
    REG_COEF_BOTTOM_RIGHT = 4'd7
  } cfg_reg_t;

  // Positions of the weights in the coefficient vector.
  localparam int COEF_TOP_LEFT     = 0;
  localparam int COEF_TOP_RIGHT    = 1;
  localparam int COEF_MID_LEFT     = 2;
  localparam int COEF_MID_RIGHT    = 3;
  localparam int COEF_BOTTOM_LEFT  = 4;
  localparam int COEF_BOTTOM_RIGHT = 5;

  // Reset values of the registers.
  localparam int WIDTH_RESET        = 640;
  localparam int HEIGHT_RESET       = 480;
  localparam int COEF_CORNER_RESET  = 16;
  localparam int COEF_MIDDLE_RESET  = 32;

  // Occupancy of the datapath stages, used for flow control.
  typedef struct packed {
    logic b_valid;
    logic b_pending;
    logic c_pending;
  } sxg_pipe_t;

endpackage

`default_nettype wire

### rtl/core/sxg_ram.sv
// ----------------------------------------------------------------------------
// sxg_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read at the address being written returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module sxg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sxg_datapath.sv
// ----------------------------------------------------------------------------
// sxg_datapath
// Position counters, the two line buffers, the window and the weighted sum.
// Stage A issues the line-buffer reads, stage B writes back and forms the
// products, stage C adds them up.
// ----------------------------------------------------------------------------
`default_nettype none

module sxg_datapath #(
  parameter int MAX_WIDTH  = sxg_pkg::MAX_WIDTH_DEFAULT,
  parameter int PIXEL_BITS = sxg_pkg::PIXEL_BITS_DEFAULT,
  parameter int COEF_BITS  = sxg_pkg::COEF_BITS_DEFAULT,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int GRAD_BITS = COEF_BITS + PIXEL_BITS + 3
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  logic [PIXEL_BITS-1:0]                         pixel_value,
  input  logic                                          frame_start,
  input  logic [sxg_pkg::DIM_BITS-1:0]                  image_width,
  input  logic [sxg_pkg::DIM_BITS-1:0]                  image_height,
  input  logic [sxg_pkg::NUM_COEFS-1:0][COEF_BITS-1:0]  coef,
  output logic                                          res_valid,
  output logic signed [GRAD_BITS-1:0]                   res_gradient,
  output logic [sxg_pkg::DIM_BITS-1:0]                  res_row,
  output logic [COL_BITS-1:0]                           res_col,
  output logic                                          res_last,
  output sxg_pkg::sxg_pipe_t                            pipe
);

  localparam int DIM  = sxg_pkg::DIM_BITS;
  localparam int WB   = (DIM > COL_BITS + 1) ? DIM : COL_BITS + 1;
  localparam int PROD = COEF_BITS + PIXEL_BITS + 1;
  localparam int NC   = sxg_pkg::NUM_COEFS;

  // ---------------- stage A: position and line-buffer read ----------------
  logic [COL_BITS-1:0] col_count;
  logic [DIM-1:0]      row_count;

  logic [WB-1:0]       width_ext, width_eff, col_ext, col_lim, col_eff_ext, col_inc;
  logic [DIM-1:0]      height_eff, row_cur;
  logic [DIM:0]        row_inc;
  logic [COL_BITS-1:0] col_cur, col_eff, col_next;
  logic [DIM-1:0]      row_next;
  logic                a_produce, a_last;

  always_comb begin
    width_ext = WB'(image_width);
    if (width_ext < WB'(3)) begin
      width_eff = WB'(3);
    end else if (width_ext > WB'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    height_eff = (image_height < DIM'(3)) ? DIM'(3) : image_height;

    col_cur     = frame_start ? '0 : col_count;
    row_cur     = frame_start ? '0 : row_count;
    col_ext     = WB'(col_cur);
    col_lim     = width_eff - WB'(1);
    col_eff_ext = (col_ext >= width_eff) ? col_lim : col_ext;
    col_eff     = col_eff_ext[COL_BITS-1:0];

    col_inc = col_eff_ext + WB'(1);
    row_inc = {1'b0, row_cur} + (DIM + 1)'(1);
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[DIM-1:0];
    end else begin
      col_next = col_inc[COL_BITS-1:0];
      row_next = row_cur;
    end

    a_produce = (row_cur >= DIM'(2)) && (col_eff >= COL_BITS'(2));
    a_last    = (row_cur == height_eff - DIM'(1)) && (col_eff_ext == col_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // ---------------- stage B: write-back, window, products ----------------
  logic                  b_valid, b_produce, b_last;
  logic [PIXEL_BITS-1:0] b_pix;
  logic [COL_BITS-1:0]   b_col;
  logic [DIM-1:0]        b_row;

  logic [PIXEL_BITS-1:0] rd_above, rd_two_above;
  logic                  fwd_hit;
  logic [PIXEL_BITS-1:0] fwd_mid, fwd_bot;
  logic [PIXEL_BITS-1:0] top_px, mid_px;
  logic [PIXEL_BITS-1:0] win [NC];
  logic signed [PROD-1:0] prod [NC];

  // The row above moves into the row two above as the new pixel is stored.
  sxg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (b_pix),
    .re    (accept),
    .raddr (col_eff),
    .rdata (rd_above)
  );

  sxg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (mid_px),
    .re    (accept),
    .raddr (col_eff),
    .rdata (rd_two_above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      b_valid <= accept;
      // A read issued while stage B writes the same entry sees stale data.
      fwd_hit <= accept && b_valid && (col_eff == b_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix     <= pixel_value;
      b_col     <= col_eff;
      b_row     <= row_cur;
      b_produce <= a_produce;
      b_last    <= a_last;
    end
    fwd_mid <= mid_px;
    fwd_bot <= b_pix;
  end

  assign top_px = fwd_hit ? fwd_mid : rd_two_above;
  assign mid_px = fwd_hit ? fwd_bot : rd_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        win[i] <= '0;
      end
    end else if (b_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_px;
      win[4] <= mid_px;
      win[5] <= b_pix;
    end
  end

  always_comb begin
    prod[0] = $signed(coef[sxg_pkg::COEF_TOP_LEFT])     * $signed({1'b0, win[0]});
    prod[1] = $signed(coef[sxg_pkg::COEF_TOP_RIGHT])    * $signed({1'b0, top_px});
    prod[2] = $signed(coef[sxg_pkg::COEF_MID_LEFT])     * $signed({1'b0, win[1]});
    prod[3] = $signed(coef[sxg_pkg::COEF_MID_RIGHT])    * $signed({1'b0, mid_px});
    prod[4] = $signed(coef[sxg_pkg::COEF_BOTTOM_LEFT])  * $signed({1'b0, win[2]});
    prod[5] = $signed(coef[sxg_pkg::COEF_BOTTOM_RIGHT]) * $signed({1'b0, b_pix});
  end

  // ---------------- stage C: sum ----------------
  logic                   c_valid, c_last;
  logic [COL_BITS-1:0]    c_col;
  logic [DIM-1:0]         c_row;
  logic signed [PROD-1:0] c_prod [NC];
  logic signed [GRAD_BITS-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid && b_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_produce) begin
      for (int i = 0; i < NC; i++) begin
        c_prod[i] <= prod[i];
      end
      c_col  <= b_col;
      c_row  <= b_row;
      c_last <= b_last;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NC; i++) begin
      sum = sum + GRAD_BITS'(c_prod[i]);
    end
  end

  assign res_valid    = c_valid;
  assign res_gradient = sum;
  assign res_row      = c_row - DIM'(1);
  assign res_col      = c_col - COL_BITS'(1);
  assign res_last     = c_last;

  assign pipe.b_valid   = b_valid;
  assign pipe.b_pending = b_valid && b_produce;
  assign pipe.c_pending = c_valid;

endmodule

`default_nettype wire

### rtl/core/sxg_out_fifo.sv
// ----------------------------------------------------------------------------
// sxg_out_fifo
// Small result queue that decouples the datapath from the output handshake.
// The producer never pushes into a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sxg_out_fifo #(
  parameter int WIDTH = 47,
  parameter int DEPTH = sxg_pkg::FIFO_DEPTH,
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic                not_empty,
  output logic [WIDTH-1:0]    head,
  output logic [CNT_BITS-1:0] count
);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

endmodule

`default_nettype wire

### rtl/core/sobel_x_gradient_3x3.sv
// ----------------------------------------------------------------------------
// sobel_x_gradient_3x3
// Horizontal 3x3 gradient on a raster-order grey pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while in_ready is high. For
// every interior pixel it offers one result item once the pixel completing
// its window has passed stages B and C into the result queue. The result is
// the weighted sum of the left and right neighbour columns, signed with four
// fraction bits, together with the row and column of the centre pixel.
// Pixels on the first two rows or columns give no result. The sustained
// rate is one item per cycle while the input is not held off. It is set by
// the line-buffer RAMs, each with one read and one write port: a RAM is read
// at the edge of acceptance and written back at the edge after, with
// forwarding when two consecutive pixels hit the same entry. A four-item
// result queue lets the input keep flowing while a finished result waits to
// be taken. The input is held off only while results already committed
// would fill that queue, and during reset. The user must write the registers
// only while the block is idle; the block does not enforce it. frame_start
// restarts the position counters, and they also wrap by themselves after the
// last pixel of a frame. The line buffers are not cleared at reset, so an
// entry is valid once the first two rows of a frame have passed it.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_x_gradient_3x3 #(
  parameter int MAX_WIDTH  = sxg_pkg::MAX_WIDTH_DEFAULT,
  parameter int PIXEL_BITS = sxg_pkg::PIXEL_BITS_DEFAULT,
  parameter int COEF_BITS  = sxg_pkg::COEF_BITS_DEFAULT,
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int GRAD_BITS = COEF_BITS + PIXEL_BITS + 3,
  localparam int CFG_BITS  = (COEF_BITS > sxg_pkg::DIM_BITS) ? COEF_BITS : sxg_pkg::DIM_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_write,
  input  logic [sxg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  // Pixel input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PIXEL_BITS-1:0]               pixel_value,
  input  logic                                frame_start,
  // Result output channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [GRAD_BITS-1:0]         gradient,
  output logic [sxg_pkg::DIM_BITS-1:0]        center_row,
  output logic [COL_BITS-1:0]                 center_col,
  output logic                                frame_last
);

  localparam int DIM       = sxg_pkg::DIM_BITS;
  localparam int NC        = sxg_pkg::NUM_COEFS;
  localparam int DEPTH     = sxg_pkg::FIFO_DEPTH;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int RES_BITS  = GRAD_BITS + DIM + COL_BITS + 1;

  // Configuration registers. The coefficients are kept in the order of the
  // register list, starting with the upper-left weight.
  logic [DIM-1:0]                image_width, image_height;
  logic [NC-1:0][COEF_BITS-1:0]  coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM'(sxg_pkg::WIDTH_RESET);
      image_height <= DIM'(sxg_pkg::HEIGHT_RESET);
      coef[sxg_pkg::COEF_TOP_LEFT]     <= COEF_BITS'(-sxg_pkg::COEF_CORNER_RESET);
      coef[sxg_pkg::COEF_TOP_RIGHT]    <= COEF_BITS'(sxg_pkg::COEF_CORNER_RESET);
      coef[sxg_pkg::COEF_MID_LEFT]     <= COEF_BITS'(-sxg_pkg::COEF_MIDDLE_RESET);
      coef[sxg_pkg::COEF_MID_RIGHT]    <= COEF_BITS'(sxg_pkg::COEF_MIDDLE_RESET);
      coef[sxg_pkg::COEF_BOTTOM_LEFT]  <= COEF_BITS'(-sxg_pkg::COEF_CORNER_RESET);
      coef[sxg_pkg::COEF_BOTTOM_RIGHT] <= COEF_BITS'(sxg_pkg::COEF_CORNER_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        sxg_pkg::REG_IMAGE_WIDTH:       image_width  <= cfg_data[DIM-1:0];
        sxg_pkg::REG_IMAGE_HEIGHT:      image_height <= cfg_data[DIM-1:0];
        sxg_pkg::REG_COEF_TOP_LEFT:
          coef[sxg_pkg::COEF_TOP_LEFT]     <= cfg_data[COEF_BITS-1:0];
        sxg_pkg::REG_COEF_TOP_RIGHT:
          coef[sxg_pkg::COEF_TOP_RIGHT]    <= cfg_data[COEF_BITS-1:0];
        sxg_pkg::REG_COEF_MID_LEFT:
          coef[sxg_pkg::COEF_MID_LEFT]     <= cfg_data[COEF_BITS-1:0];
        sxg_pkg::REG_COEF_MID_RIGHT:
          coef[sxg_pkg::COEF_MID_RIGHT]    <= cfg_data[COEF_BITS-1:0];
        sxg_pkg::REG_COEF_BOTTOM_LEFT:
          coef[sxg_pkg::COEF_BOTTOM_LEFT]  <= cfg_data[COEF_BITS-1:0];
        sxg_pkg::REG_COEF_BOTTOM_RIGHT:
          coef[sxg_pkg::COEF_BOTTOM_RIGHT] <= cfg_data[COEF_BITS-1:0];
        default: ; // Writes beyond the register list are dropped.
      endcase
    end
  end

  // Datapath: counters, line buffers, window and the weighted sum.
  logic                        accept;
  logic                        res_valid, res_last;
  logic signed [GRAD_BITS-1:0] res_gradient;
  logic [DIM-1:0]              res_row;
  logic [COL_BITS-1:0]         res_col;
  sxg_pkg::sxg_pipe_t          pipe;

  assign accept = in_valid && in_ready;

  sxg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel_value  (pixel_value),
    .frame_start  (frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .coef         (coef),
    .res_valid    (res_valid),
    .res_gradient (res_gradient),
    .res_row      (res_row),
    .res_col      (res_col),
    .res_last     (res_last),
    .pipe         (pipe)
  );

  // Result queue. Once a pixel is accepted its result cannot be held back,
  // so the input is only ready while the queue has room for every result
  // still travelling through stages B and C plus the one that may follow.
  logic [RES_BITS-1:0] fifo_head;
  logic [CNT_BITS-1:0] fifo_count;
  logic [CNT_BITS:0]   committed;

  sxg_out_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_gradient, res_row, res_col, res_last}),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  assign committed = (CNT_BITS + 1)'(fifo_count)
                   + (CNT_BITS + 1)'(pipe.b_pending)
                   + (CNT_BITS + 1)'(pipe.c_pending);
  // No item is taken while reset is held, since the pipeline would drop it.
  assign in_ready  = !rst && (committed < (CNT_BITS + 1)'(DEPTH));

  assign {gradient, center_row, center_col, frame_last} = fifo_head;

  // The queue never has to take more results than it can hold.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    committed <= (CNT_BITS + 1)'(DEPTH))
    else $error("result queue overcommitted");

  // An accepted pixel is always in stage B in the following cycle.
  a_accept_to_b : assert property (@(posedge clk) disable iff (rst)
    accept |=> pipe.b_valid)
    else $error("accepted pixel did not reach stage B");

  // A result never belongs to a border pixel.
  a_interior_only : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_row != '0) && (center_col != '0))
    else $error("result item for a border pixel");

endmodule

`default_nettype wire
